// ===== rtl/core/pesa_pkg.sv =====
package pesa_pkg;
    localparam int DATA_W = 32;
    localparam int DEF_STACK_DEPTH = 64;
    localparam logic [3:0] CMD_PUSH = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
        CMD_DIV = 4'd4, CMD_MOD = 4'd5, CMD_AND = 4'd6, CMD_OR = 4'd7, CMD_GT = 4'd8,
        CMD_LT = 4'd9, CMD_EQ = 4'd10, CMD_NE = 4'd11, CMD_LE = 4'd12, CMD_GE = 4'd13,
        CMD_NOT = 4'd14, CMD_NEG = 4'd15;
    localparam logic [1:0] ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZERO = 2'd3;

    // stack operation broadcast to every cell
    typedef struct packed {
        logic push;   // shift down, new top
        logic pop;    // shift up, new top
        logic repl;   // replace top only
        logic clr;    // empty the whole chain
    } stk_op_t;
endpackage

// ===== rtl/core/pesa_cell.sv =====
module pesa_cell import pesa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  stk_op_t           op,
    input  logic [DATA_W-1:0] new_top,
    input  logic [DATA_W-1:0] above_data,
    input  logic              above_vld,
    input  logic [DATA_W-1:0] below_data,
    input  logic              below_vld,
    input  logic              is_top,
    output logic [DATA_W-1:0] data,
    output logic              vld
);
    logic [DATA_W-1:0] data_reg;
    logic              vld_reg;
    assign data = data_reg;
    assign vld  = vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || op.clr) begin
            vld_reg <= 1'b0;
        end else if (op.push) begin
            vld_reg <= above_vld;
        end else if (op.pop) begin
            vld_reg <= below_vld;
        end
        // cell 0 is the top: it takes the new value; others shift
        if (op.push) begin
            data_reg <= is_top ? new_top : above_data;
        end else if (op.pop) begin
            data_reg <= is_top ? new_top : below_data;
        end else if (op.repl && is_top) begin
            data_reg <= new_top;
        end
    end
endmodule

// ===== rtl/core/pesa_divider.sv =====
module pesa_divider import pesa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DATA_W-1:0] quot,
    output logic [DATA_W-1:0] rem
);
    localparam int CW = $clog2(DATA_W + 1);
    logic [DATA_W-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W:0]   trial;
    assign busy = cnt_reg != '0;
    assign quot = q_reg;
    assign rem  = r_reg;
    assign trial = {r_reg, q_reg[DATA_W-1]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(DATA_W);
            q_reg   <= dividend;
            r_reg   <= '0;
            d_reg   <= divisor;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!trial[DATA_W]) begin
                r_reg <= trial[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b1};
            end else begin
                r_reg <= {r_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                q_reg <= {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/core/prefix_expression_stack_alu_top.sv =====
// Prefix expression evaluator. Tokens arrive last token first on the s_ channel; each
// accepted transaction yields one m_ transaction with the top of stack, the depth, a
// status and an echo of s_last. The operand stack is a chain of STACK_DEPTH cells that
// shift together, cell 0 holding the top, so every push, pop or replace is a single update of the chain.
// For any operator but div and mod, the accepted token passes through S_EXEC, which
// drives the cell chain and sets the m_valid register; the result is read straight off
// cell 0 and the depth register. Div and mod start the divider from S_EXEC, wait in
// S_DIV through the 32 steps of the restoring divider until it is idle, then write back
// from S_FIN. One token is in flight at a time: s_ready stays low until the result
// transaction has gone. No clearing pass after reset: valid bits per cell.
module prefix_expression_stack_alu_top import pesa_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_cmd,
    input  logic [23:0]              s_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_top_value,
    output logic [6:0]               m_depth,
    output logic [1:0]               m_status,
    output logic                     m_done_res
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_DIV = 2'd2, S_FIN = 2'd3;

    logic [1:0]        state_reg;
    logic [3:0]        cmd_reg;
    logic [23:0]       val_reg;
    logic              last_reg;
    logic [SPW-1:0]    sp_reg;
    logic [1:0]        st_reg;
    logic              mv_reg;
    logic [DATA_W-1:0] a, b, res, ma, mb, qs, rs;
    logic [DATA_W-1:0] cdata [STACK_DEPTH];
    logic              cvld  [STACK_DEPTH];
    logic              dstart, dbusy;
    logic [DATA_W-1:0] dq, dr;
    logic [DATA_W-1:0] prod;
    stk_op_t           op;

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign a = cdata[0];
    assign b = cdata[1];
    assign ma = a[DATA_W-1] ? -a : a;
    assign mb = b[DATA_W-1] ? -b : b;
    assign prod = a * b;
    assign qs = (a[DATA_W-1] ^ b[DATA_W-1]) ? -dq : dq;
    assign rs = a[DATA_W-1] ? -dr : dr;

    // result of each command: the operators, the pushed value, and the signed quotient or remainder for div and mod
    always_comb begin
        unique case (cmd_reg)
            CMD_ADD: res = a + b;
            CMD_SUB: res = a - b;
            CMD_MUL: res = prod;
            CMD_AND: res = DATA_W'(a != '0 && b != '0);
            CMD_OR:  res = DATA_W'(a != '0 || b != '0);
            CMD_GT:  res = DATA_W'($signed(a) > $signed(b));
            CMD_LT:  res = DATA_W'($signed(a) < $signed(b));
            CMD_EQ:  res = DATA_W'(a == b);
            CMD_NE:  res = DATA_W'(a != b);
            CMD_LE:  res = DATA_W'($signed(a) <= $signed(b));
            CMD_GE:  res = DATA_W'($signed(a) >= $signed(b));
            CMD_NOT: res = DATA_W'(a == '0);
            CMD_NEG: res = -a;
            CMD_PUSH: res = DATA_W'(val_reg);
            default: res = (cmd_reg == CMD_DIV) ? qs : rs;
        endcase
    end

    logic is_div, under, over, dz;
    assign is_div = cmd_reg == CMD_DIV || cmd_reg == CMD_MOD;
    assign over   = cmd_reg == CMD_PUSH && sp_reg >= SPW'(STACK_DEPTH);
    assign under  = (cmd_reg >= CMD_NOT) ? (sp_reg == '0)
                  : (cmd_reg != CMD_PUSH && sp_reg < SPW'(2));
    assign dz     = is_div && b == '0;
    assign dstart = state_reg == S_EXEC && is_div && !under && !dz;

    // drive the chain: execute ops in S_EXEC (or S_FIN for div and mod), clear when the last result is taken
    always_comb begin
        op = '0;
        if (state_reg == S_EXEC && !over && !under && !dz && !is_div) begin
            op.push = cmd_reg == CMD_PUSH;
            op.repl = cmd_reg >= CMD_NOT;
            op.pop  = !op.push && !op.repl;
        end else if (state_reg == S_FIN) begin
            op.pop = 1'b1;
        end
        if (mv_reg && m_ready && m_done_res) op = '{clr: 1'b1, default: 1'b0};
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        pesa_cell u_cell (
            .aclk, .aresetn, .op, .new_top(res),
            .above_data(i == 0 ? res : cdata[(i == 0) ? 0 : i - 1]),
            .above_vld(i == 0 ? 1'b1 : cvld[(i == 0) ? 0 : i - 1]),
            .below_data(cdata[(i == STACK_DEPTH - 1) ? i : i + 1]),
            .below_vld(i == STACK_DEPTH - 1 ? 1'b0 : cvld[(i == STACK_DEPTH - 1) ? i : i + 1]),
            .is_top(i == 0), .data(cdata[i]), .vld(cvld[i])
        );
    end

    pesa_divider u_div (
        .aclk, .aresetn, .start(dstart), .dividend(ma), .divisor(mb),
        .busy(dbusy), .quot(dq), .rem(dr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
                if (m_done_res) sp_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= S_EXEC;
                        cmd_reg <= s_cmd; val_reg <= s_value; last_reg <= s_last;
                    end
                end
                S_EXEC: begin
                    // hold status, advance depth for the ops other than div and mod
                    st_reg <= over ? ST_OVER : under ? ST_UNDER : dz ? ST_DIVZERO : ST_OK;
                    if (dstart) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_IDLE;
                        mv_reg    <= 1'b1;
                        if (op.push) sp_reg <= sp_reg + 1'b1;
                        if (op.pop)  sp_reg <= sp_reg - 1'b1;
                    end
                end
                S_DIV: begin
                    if (!dbusy) state_reg <= S_FIN;
                end
                default: begin
                    state_reg <= S_IDLE;
                    mv_reg    <= 1'b1;
                    sp_reg    <= sp_reg - 1'b1;
                end
            endcase
        end
    end

    assign m_valid     = mv_reg;
    assign m_top_value = cvld[0] ? $signed(cdata[0]) : '0;
    assign m_depth     = 7'(sp_reg);
    assign m_status    = st_reg;
    assign m_done_res  = last_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_depth_max: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("depth beyond stack");
    a_top_vld: assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg != '0) == cvld[0]) else $error("top valid bit mismatch");
    a_div_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        dstart |=> state_reg == S_DIV) else $error("divider not entered");
`endif
endmodule

// ===== test/prefix_expression_stack_alu_top_tb.sv =====
`timescale 1ns / 1ps

module prefix_expression_stack_alu_top_tb;
    import pesa_pkg::*;

    localparam int DEPTH_MAX = DEF_STACK_DEPTH;
    localparam int N_RANDOM = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_cmd = CMD_PUSH;
    logic [23:0]       s_value = '0;
    logic              s_last = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [31:0] m_top_value;
    logic [6:0]        m_depth;
    logic [1:0]        m_status;
    logic              m_done_res;

    typedef struct packed {
        logic [31:0] top_value;
        logic [6:0]  depth;
        logic [1:0]  status;
        logic        done_res;
    } eval_result_t;

    typedef struct {
        logic [3:0]  cmd;
        logic [23:0] value;
        logic        last;
        logic        has_golden;  // typed-in result present
        eval_result_t golden;
    } token_row_t;

    prefix_expression_stack_alu_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_depth     (m_depth),
        .m_status    (m_status),
        .m_done_res  (m_done_res)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the operand stack, index 0 is the bottom
    logic [31:0]  shadow_stack [DEPTH_MAX];
    int unsigned  shadow_sp;
    eval_result_t pending_results [$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    logic         hold_off_request;  // ask the receiver for a long stall
    token_row_t   directed_rows [$];

    function automatic logic [31:0] magnitude_of(logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // Advance the shadow stack by one token and return the result it yields
    function automatic eval_result_t evaluate_token(logic [3:0] cmd, logic [23:0] value,
                                                    logic last);
        eval_result_t res;
        logic [31:0] a, b, r;
        logic [1:0] st;
        st = ST_OK;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (shadow_sp >= DEPTH_MAX) st = ST_OVER;
            else begin
                shadow_stack[shadow_sp] = {8'd0, value};
                shadow_sp++;
            end
        end else if (cmd == CMD_NOT || cmd == CMD_NEG) begin
            if (shadow_sp < 1) st = ST_UNDER;
            else begin
                a = shadow_stack[shadow_sp-1];
                shadow_stack[shadow_sp-1] = (cmd == CMD_NOT) ? {31'd0, a == 0} : 32'd0 - a;
            end
        end else if (shadow_sp < 2) begin
            st = ST_UNDER;
        end else begin
            a = shadow_stack[shadow_sp-1];
            b = shadow_stack[shadow_sp-2];
            case (cmd)
                CMD_ADD: r = a + b;
                CMD_SUB: r = a - b;
                CMD_MUL: r = a * b;
                CMD_DIV: begin
                    if (b == 0) st = ST_DIVZERO;
                    else begin
                        r = magnitude_of(a) / magnitude_of(b);
                        if (a[31] ^ b[31]) r = 32'd0 - r;
                    end
                end
                CMD_MOD: begin
                    if (b == 0) st = ST_DIVZERO;
                    else begin
                        r = magnitude_of(a) % magnitude_of(b);
                        if (a[31]) r = 32'd0 - r;
                    end
                end
                CMD_AND: r = {31'd0, (a != 0) && (b != 0)};
                CMD_OR:  r = {31'd0, (a != 0) || (b != 0)};
                CMD_GT:  r = {31'd0, $signed(a) > $signed(b)};
                CMD_LT:  r = {31'd0, $signed(a) < $signed(b)};
                CMD_EQ:  r = {31'd0, a == b};
                CMD_NE:  r = {31'd0, a != b};
                CMD_LE:  r = {31'd0, $signed(a) <= $signed(b)};
                default: r = {31'd0, $signed(a) >= $signed(b)};
            endcase
            if (st == ST_OK) begin
                shadow_sp--;
                shadow_stack[shadow_sp-1] = r;
            end
        end
        res.top_value = (shadow_sp > 0) ? shadow_stack[shadow_sp-1] : 32'd0;
        res.depth = shadow_sp[6:0];
        res.status = st;
        res.done_res = last;
        if (last) shadow_sp = 0;
        return res;
    endfunction

    function automatic token_row_t make_row(logic [3:0] cmd, logic [23:0] value, logic last);
        token_row_t row;
        row.cmd = cmd;
        row.value = value;
        row.last = last;
        row.has_golden = 1'b0;
        row.golden = '0;
        return row;
    endfunction

    function automatic token_row_t make_checked_row(logic [3:0] cmd, logic [23:0] value,
                                                    logic last, logic [31:0] top,
                                                    logic [6:0] depth, logic [1:0] st);
        token_row_t row;
        row = make_row(cmd, value, last);
        row.has_golden = 1'b1;
        row.golden = '{top, depth, st, last};
        return row;
    endfunction

    // Offer one transaction; burst gaps are decided by the caller
    task automatic send_token(logic [3:0] cmd, logic [23:0] value, logic last,
                              logic has_golden, eval_result_t golden);
        eval_result_t predicted;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= value;
        s_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = evaluate_token(cmd, value, last);
        if (has_golden && predicted != golden) begin
            $error("directed row disagrees with predictor: cmd %0d", cmd);
            error_count++;
        end
        pending_results.push_back(predicted);
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Random operand value: zero, all ones, a large decimal, a small digit or raw noise
    function automatic logic [23:0] random_value();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'd9999999;
            3: return 24'($urandom_range(0, 9));
            default: return 24'($urandom);
        endcase
    endfunction

    // Check: compare each result with the oldest prediction
    always @(posedge aclk) begin
        eval_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: top_value %0d", m_top_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_top_value !== want.top_value) begin
                    $error("top_value: expected %0d, actual %0d",
                           $signed(want.top_value), m_top_value);
                    error_count++;
                end
                if (m_depth !== want.depth) begin
                    $error("depth: expected %0d, actual %0d", want.depth, m_depth);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
                if (m_done_res !== want.done_res) begin
                    $error("done_res: expected %0d, actual %0d", want.done_res, m_done_res);
                    error_count++;
                end
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off when asked
    always @(posedge aclk) begin
        int unsigned hold_count;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_count = 0;
        end else if (hold_off_request && hold_count == 0) begin
            hold_count = 300;
            m_ready <= 1'b0;
        end else if (hold_count > 1) begin
            hold_count--;
            m_ready <= 1'b0;
        end else begin
            if (hold_count == 1) hold_count = 0;
            case ((cycle_count / 200) % 3)
                0: m_ready <= 1'b1;                       // no stalls
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("prefix_expression_stack_alu_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned burst;
        int unsigned sent;
        int unsigned expr_len;
        int unsigned depth_now;
        logic [3:0] op;
        logic [23:0] val;
        logic fin;
        error_count = 0;
        cycle_count = 0;
        shadow_sp = 0;
        hold_off_request = 1'b0;

        // Directed table: underflow, zero divided and taken modulo, divide by zero, arithmetic corners
        directed_rows.push_back(make_checked_row(CMD_ADD, 24'd0, 1'b0, 32'd0, 7'd0, ST_UNDER));
        directed_rows.push_back(make_checked_row(CMD_NOT, 24'd0, 1'b0, 32'd0, 7'd0, ST_UNDER));
        directed_rows.push_back(make_checked_row(CMD_PUSH, 24'hFF_FFFF, 1'b0,
                                                 32'h00FF_FFFF, 7'd1, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_SUB, 24'd0, 1'b0,
                                                 32'h00FF_FFFF, 7'd1, ST_UNDER));
        directed_rows.push_back(make_checked_row(CMD_PUSH, 24'd0, 1'b0, 32'd0, 7'd2, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_DIV, 24'd0, 1'b0, 32'd0, 7'd1, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_NOT, 24'd0, 1'b0, 32'd1, 7'd1, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_PUSH, 24'd0, 1'b0, 32'd0, 7'd2, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_MOD, 24'd0, 1'b1, 32'd0, 7'd1, ST_OK));
        // b = 0 but a != 0 on the stack: divide by zero
        directed_rows.push_back(make_row(CMD_PUSH, 24'd0, 1'b0));
        directed_rows.push_back(make_row(CMD_PUSH, 24'd7, 1'b0));
        directed_rows.push_back(make_checked_row(CMD_DIV, 24'd0, 1'b1, 32'd7, 7'd2, ST_DIVZERO));
        // most negative value negated, then divided by -1
        directed_rows.push_back(make_row(CMD_PUSH, 24'd1, 1'b0));
        directed_rows.push_back(make_row(CMD_NEG, 24'd0, 1'b0));
        directed_rows.push_back(make_row(CMD_PUSH, 24'd1, 1'b0));
        directed_rows.push_back(make_row(CMD_PUSH, 24'h80_0000, 1'b0));
        directed_rows.push_back(make_row(CMD_PUSH, 24'd256, 1'b0));
        directed_rows.push_back(make_row(CMD_MUL, 24'd0, 1'b0));
        directed_rows.push_back(make_row(CMD_MUL, 24'd0, 1'b0));
        directed_rows.push_back(make_checked_row(CMD_NEG, 24'd0, 1'b0, INT_MIN, 7'd2, ST_OK));
        directed_rows.push_back(make_checked_row(CMD_DIV, 24'd0, 1'b1, INT_MIN, 7'd1, ST_OK));
        for (int i = 0; i < directed_rows.size(); i++) begin
            // nothing
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_token(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].last,
                       directed_rows[i].has_golden, directed_rows[i].golden);
        // every operator from add to negate on signed operands
        for (int c = CMD_ADD; c <= CMD_NEG; c++) begin
            send_token(CMD_PUSH, 24'd3, 1'b0, 1'b0, '0);
            send_token(CMD_NEG, 24'd0, 1'b0, 1'b0, '0);
            send_token(CMD_PUSH, 24'd5, 1'b0, 1'b0, '0);
            send_token(4'(c), 24'd0, 1'b1, 1'b0, '0);
        end
        // fill to overflow, and drain with a single last token
        for (int i = 0; i <= DEPTH_MAX; i++)
            send_token(CMD_PUSH, 24'(i), i == DEPTH_MAX, 1'b0, '0);

        // pause until every result has come
        drain_results();

        // receiver holds off while the sender keeps offering
        hold_off_request <= 1'b1;
        @(posedge aclk);
        hold_off_request <= 1'b0;
        for (int i = 0; i < 8; i++)
            send_token(CMD_PUSH, random_value(), 1'b0, 1'b0, '0);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < N_RANDOM) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise token
                    send_token(4'($urandom), random_value(), 1'($urandom), 1'b0, '0);
                    sent++;
                    burst--;
                end else begin
                    // build a prefix expression bottom-up; mostly valid operator choices
                    expr_len = $urandom_range(1, 10);
                    depth_now = shadow_sp;
                    for (int k = 0; k < expr_len; k++) begin
                        fin = (k == expr_len - 1) && ($urandom_range(0, 3) != 0);
                        if (depth_now < 2 || $urandom_range(0, 2) == 0) begin
                            op = (depth_now >= 1 && $urandom_range(0, 4) == 0)
                                 ? ($urandom_range(0, 1) ? CMD_NOT : CMD_NEG) : CMD_PUSH;
                        end else begin
                            op = 4'($urandom_range(CMD_ADD, CMD_GE));
                        end
                        val = random_value();
                        send_token(op, val, fin, 1'b0, '0);
                        depth_now = shadow_sp;
                        sent++;
                    end
                    burst--;
                end
            end
            idle_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
        end

        s_valid <= 1'b0;
        drain_results();
        repeat (60) @(posedge aclk);
        if (error_count == 0)
            $display("prefix_expression_stack_alu_top_tb: PASS");
        else
            $display("prefix_expression_stack_alu_top_tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pesa_pkg.sv
rtl/core/pesa_cell.sv
rtl/core/pesa_divider.sv
rtl/core/prefix_expression_stack_alu_top.sv
test/prefix_expression_stack_alu_top_tb.sv
